/* hw/rtl/ndrg_pkg.sv */
// Shared constants, types and helpers for the NACK duplicate rate guard.
// No dependencies; every other file but ndrg_ram imports this package.
package ndrg_pkg;

   localparam int GUARD_ENTRIES = 8;
   localparam int PEER_ID_BYTES = 4;

   localparam int IDX_W    = (GUARD_ENTRIES > 1) ? $clog2(GUARD_ENTRIES) : 1;
   localparam int SLOT_W   = 3;
   localparam int PEER_W   = 32;
   localparam int PACKET_W = 16;
   localparam int TIME_W   = 32;
   localparam int WINDOW_W = 16;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd800;

   localparam logic [PEER_W-1:0] PEER_MASK = (PEER_ID_BYTES >= 4) ? {PEER_W{1'b1}} :
      PEER_W'((64'd1 << (8 * PEER_ID_BYTES)) - 64'd1);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GUARD_ENTRIES - 1);

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [PEER_W-1:0]   peer;
      logic [PACKET_W-1:0] packet;
      logic [TIME_W-1:0]   stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic is_free;
      logic expired;
      logic match;
      logic older;
   } eval_type;

   function automatic logic [SLOT_W-1:0] to_slot(input idx_type idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[SLOT_W-1:0];
   endfunction

endpackage

/* hw/rtl/ndrg_channels.sv */
// Request and response channel interfaces of the NACK duplicate rate guard.
// Depends on ndrg_pkg for field widths.
interface ndrg_req_if import ndrg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PEER_W-1:0]   peer_id;
   logic [PACKET_W-1:0] packet_id;
   logic [TIME_W-1:0]   now_ms;

   modport source (output valid, output peer_id, output packet_id, output now_ms,
                   input ready);
   modport sink (input valid, input peer_id, input packet_id, input now_ms,
                 output ready);
endinterface

interface ndrg_rsp_if import ndrg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              limited;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, output limited, output slot, input ready);
   modport sink (input valid, input limited, input slot, output ready);
endinterface

/* hw/rtl/ndrg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ndrg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/ndrg_entry_eval.sv */
// Compare unit shared by every scan step: age test, id match, oldest test.
// Depends on ndrg_pkg.
module ndrg_entry_eval import ndrg_pkg::*; (
   input  entry_type           entry,
   input  logic [PEER_W-1:0]   peer,
   input  logic [PACKET_W-1:0] packet,
   input  logic [TIME_W-1:0]   now,
   input  logic [WINDOW_W-1:0] window,
   input  logic [TIME_W-1:0]   ref_ts,
   output eval_type            result
);

   logic [TIME_W-1:0] age;
   logic              ids_equal;

   assign age       = now - entry.stamp;
   assign ids_equal = (((entry.peer ^ peer) & PEER_MASK) == '0) && (entry.packet == packet);

   always_comb begin
      result.is_free = (entry.stamp == '0);
      result.expired = !result.is_free && (age > TIME_W'(window));
      result.match   = !result.is_free && !result.expired && ids_equal;
      result.older   = entry.stamp < ref_ts;
   end

endmodule

/* hw/rtl/nack_duplicate_rate_guard.sv */
// Top level of the NACK duplicate rate guard: sequencer, guard table, output register.
// Depends on ndrg_pkg, ndrg_channels, ndrg_ram and ndrg_entry_eval.
//
//   channel  | direction | handshake       | payload
//   req      | in        | valid / ready   | peer_id, packet_id, now_ms
//   rsp      | out       | valid / ready   | limited, slot
//   csr      | in        | csr_we (no ack) | csr_wdata = window_ms
//
// A request passes an accept state, a scan of one table entry per cycle through the single
// RAM read port (ending early at an expired or matching entry), and a decide/write state.
// Reset clears the valid bits of the table at once and loads window_ms with 800.
// A pending response does not block the next scan; the decide cycle holds until
// the output register is free.
module nack_duplicate_rate_guard import ndrg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   ndrg_req_if.sink            req,
   ndrg_rsp_if.source          rsp,
   input  logic                csr_we,
   input  logic [WINDOW_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   idx_type             idx_ff, idx_in;
   logic                have_free_ff, have_free_in;
   idx_type             free_idx_ff, free_idx_in;
   idx_type             oldest_idx_ff, oldest_idx_in;
   logic [TIME_W-1:0]   oldest_ts_ff, oldest_ts_in;
   logic                hit_ff, hit_in;
   idx_type             hit_idx_ff, hit_idx_in;
   logic [WINDOW_W-1:0] window_ff;
   logic [PEER_W-1:0]   peer_ff;
   logic [PACKET_W-1:0] packet_ff;
   logic [TIME_W-1:0]   now_ff;
   logic                rd_valid_ff;
   logic                entry_valid_ff [GUARD_ENTRIES];
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_limited_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;

   logic                req_take;
   logic                out_free;
   logic                finish;
   idx_type             raddr;
   idx_type             pick;
   logic [ENTRY_W-1:0]  rdata;
   entry_type           entry;
   entry_type           wentry;
   logic                wr_en;
   logic [TIME_W-1:0]   ref_ts;
   eval_type            ev;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_take  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign finish    = (state_ff == ST_DONE) && out_free;
   assign pick      = hit_ff ? hit_idx_ff : (have_free_ff ? free_idx_ff : oldest_idx_ff);
   assign wr_en     = finish && !hit_ff;

   assign wentry.peer   = peer_ff;
   assign wentry.packet = packet_ff;
   assign wentry.stamp  = now_ff;

   always_comb begin
      if (state_ff == ST_SCAN && idx_ff != LAST_IDX) begin
         raddr = idx_ff + 1'b1;
      end else begin
         raddr = '0;
      end
   end

   ndrg_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (GUARD_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (wr_en),
      .waddr (pick),
      .wdata (wentry),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign entry  = rd_valid_ff ? entry_type'(rdata) : '0;
   assign ref_ts = (idx_ff == '0) ? entry.stamp : oldest_ts_ff;

   ndrg_entry_eval u_eval (
      .entry  (entry),
      .peer   (peer_ff),
      .packet (packet_ff),
      .now    (now_ff),
      .window (window_ff),
      .ref_ts (ref_ts),
      .result (ev)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      have_free_in  = have_free_ff;
      free_idx_in   = free_idx_ff;
      oldest_idx_in = oldest_idx_ff;
      oldest_ts_in  = oldest_ts_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in     = ST_SCAN;
               idx_in       = '0;
               have_free_in = 1'b0;
               hit_in       = 1'b0;
            end
         end
         ST_SCAN: begin
            if (idx_ff == '0) begin
               oldest_ts_in  = entry.stamp;
               oldest_idx_in = '0;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end
            if (ev.is_free) begin
               if (!have_free_ff) begin
                  have_free_in = 1'b1;
                  free_idx_in  = idx_ff;
               end
            end else if (ev.expired) begin
               have_free_in = 1'b1;
               free_idx_in  = idx_ff;
               state_in     = ST_DONE;
            end else if (ev.match) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
               state_in   = ST_DONE;
            end else if (ev.older) begin
               oldest_ts_in  = entry.stamp;
               oldest_idx_in = idx_ff;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_RESET;
         rd_valid_ff  <= 1'b0;
         for (int i = 0; i < GUARD_ENTRIES; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= entry_valid_ff[raddr];
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
         if (wr_en) begin
            entry_valid_ff[pick] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      have_free_ff  <= have_free_in;
      free_idx_ff   <= free_idx_in;
      oldest_idx_ff <= oldest_idx_in;
      oldest_ts_ff  <= oldest_ts_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      if (req_take) begin
         peer_ff   <= req.peer_id;
         packet_ff <= req.packet_id;
         now_ff    <= req.now_ms;
      end
      if (finish) begin
         rsp_limited_ff <= hit_ff;
         rsp_slot_ff    <= to_slot(pick);
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.limited = rsp_limited_ff;
   assign rsp.slot    = rsp_slot_ff;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for nack_duplicate_rate_guard: directed and random NACK requests
// scored against a guard-table predictor. Depends on ndrg_pkg and the ndrg_channels interfaces.
module testbench import ndrg_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int END_SETTLE     = 12;

   typedef struct packed {
      logic              limited;
      logic [SLOT_W-1:0] slot;
   } verdict_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_we;
   logic [WINDOW_W-1:0] csr_wdata;

   ndrg_req_if req_if ();
   ndrg_rsp_if rsp_if ();

   nack_duplicate_rate_guard i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   logic [PEER_W-1:0]   tbl_peer [GUARD_ENTRIES];
   logic [PACKET_W-1:0] tbl_packet [GUARD_ENTRIES];
   logic [TIME_W-1:0]   tbl_stamp [GUARD_ENTRIES];
   logic [WINDOW_W-1:0] window_limit;

   verdict_type pending_verdicts [$];
   int          error_count = 0;
   int          response_count = 0;
   int          hold_off_left = 0;
   int          rsp_gap_left = 0;
   bit          quiet_gaps = 1'b0;

   function automatic verdict_type predict_nack_verdict(input logic [PEER_W-1:0] peer,
                                                        input logic [PACKET_W-1:0] packet,
                                                        input logic [TIME_W-1:0] now);
      verdict_type       verdict;
      bit                have_free;
      int                free_idx;
      int                oldest_idx;
      int                pick;
      int                i;
      logic [TIME_W-1:0] oldest_stamp;
      logic [TIME_W-1:0] age;
      have_free    = 1'b0;
      free_idx     = 0;
      oldest_idx   = 0;
      oldest_stamp = tbl_stamp[0];
      for (i = 0; i < GUARD_ENTRIES; i++) begin
         if (tbl_stamp[i] == '0) begin
            if (!have_free) begin
               have_free = 1'b1;
               free_idx  = i;
            end
            continue;
         end
         age = now - tbl_stamp[i];
         if (age > TIME_W'(window_limit)) begin
            have_free = 1'b1;
            free_idx  = i;
            break;
         end
         if ((((tbl_peer[i] ^ peer) & PEER_MASK) == '0) && (tbl_packet[i] == packet)) begin
            verdict.limited = 1'b1;
            verdict.slot    = i[SLOT_W-1:0];
            return verdict;
         end
         if (tbl_stamp[i] < oldest_stamp) begin
            oldest_stamp = tbl_stamp[i];
            oldest_idx   = i;
         end
      end
      pick             = have_free ? free_idx : oldest_idx;
      tbl_peer[pick]   = peer;
      tbl_packet[pick] = packet;
      tbl_stamp[pick]  = now;
      verdict.limited  = 1'b0;
      verdict.slot     = pick[SLOT_W-1:0];
      return verdict;
   endfunction

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_gaps || r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0h expected %0h at response %0d", what, got, want,
               response_count);
      error_count++;
   endtask

   task automatic send_request(input logic [PEER_W-1:0] peer,
                               input logic [PACKET_W-1:0] packet,
                               input logic [TIME_W-1:0] now);
      int gap;
      req_if.valid     <= 1'b1;
      req_if.peer_id   <= peer;
      req_if.packet_id <= packet;
      req_if.now_ms    <= now;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_verdicts.push_back(predict_nack_verdict(peer, packet, now));
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_verdicts();
      req_if.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_W-1:0] value);
      wait_for_verdicts();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      window_limit = value;
      csr_we <= 1'b0;
   endtask

   task automatic test_table_fill_and_match();
      int k;
      send_request('0, '0, 100);
      send_request('1, '1, 110);
      for (k = 2; k < 9; k++) send_request(k * 32'h0101_0101, PACKET_W'(k), 100 + k * 10);
      send_request('1, '1, 300);
      send_request('1, '0, 310);
      send_request('0, '1, 320);
   endtask

   task automatic test_time_zero_and_wrap();
      send_request(32'h1234_5678, 16'h4242, 0);
      send_request(32'h1234_5678, 16'h4242, 0);
      send_request(32'hA5A5_A5A5, 16'h5A5A, 32'hFFFF_FFF0);
      send_request(32'hA5A5_A5A5, 16'h5A5A, 5);
   endtask

   task automatic test_window_extremes();
      write_window('0);
      send_request(32'h0BAD_F00D, 16'h0101, 1000);
      send_request(32'h0BAD_F00D, 16'h0101, 1000);
      send_request(32'h0BAD_F00D, 16'h0101, 1001);
      write_window('1);
      send_request(32'h0BAD_F00D, 16'h0101, 1001 + 65535);
      write_window(1);
      send_request(32'h0BAD_F00D, 16'h0101, 1003 + 65535);
   endtask

   task automatic test_input_backpressure();
      int k;
      logic [TIME_W-1:0] now;
      write_window(800);
      now           = $urandom;
      quiet_gaps    = 1'b1;
      hold_off_left = 300;
      for (k = 0; k < 16; k++) begin
         now += $urandom_range(0, 40);
         send_request(32'hC0DE_0000 | $urandom_range(0, 5), PACKET_W'($urandom_range(0, 3)),
                      now);
      end
      quiet_gaps = 1'b0;
   endtask

   task automatic run_traffic_phase(input int count, input logic [WINDOW_W-1:0] window);
      logic [PEER_W-1:0]   pool_peer [4];
      logic [PACKET_W-1:0] pool_packet [4];
      logic [TIME_W-1:0]   clock_ms;
      int                  step_max;
      int                  k;
      int                  r;
      write_window(window);
      for (k = 0; k < 4; k++) begin
         pool_peer[k]   = $urandom;
         pool_packet[k] = PACKET_W'($urandom_range(0, 65535));
      end
      clock_ms = $urandom;
      step_max = int'(window) / 6 + 2;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 85) begin
            clock_ms += $urandom_range(0, step_max);
            send_request(pool_peer[$urandom_range(0, 3)], pool_packet[$urandom_range(0, 3)],
                         clock_ms);
         end else if (r < 95) begin
            send_request($urandom, PACKET_W'($urandom_range(0, 65535)),
                         clock_ms + $urandom_range(0, step_max));
         end else begin
            send_request($urandom, PACKET_W'($urandom_range(0, 65535)), $urandom);
         end
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(140, 800);
      run_traffic_phase(140, WINDOW_W'($urandom_range(1, 65535)));
      quiet_gaps = 1'b1;
      run_traffic_phase(140, 1);
      quiet_gaps = 1'b0;
      run_traffic_phase(140, '1);
      run_traffic_phase(120, '0);
      run_traffic_phase(140, WINDOW_W'($urandom_range(2, 200)));
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_off_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off_left--;
         end else if (rsp_gap_left > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_gap_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            rsp_gap_left = draw_gap();
         end
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected response slot", int'(rsp_if.slot), 0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_if.limited !== want.limited)
               report_mismatch("limited", int'(rsp_if.limited), int'(want.limited));
            if (rsp_if.slot !== want.slot)
               report_mismatch("slot", int'(rsp_if.slot), int'(want.slot));
         end
         response_count++;
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int i;
      for (i = 0; i < GUARD_ENTRIES; i++) begin
         tbl_peer[i]   = '0;
         tbl_packet[i] = '0;
         tbl_stamp[i]  = '0;
      end
      window_limit      = WINDOW_RESET;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_wdata        <= '0;
      req_if.valid     <= 1'b0;
      req_if.peer_id   <= '0;
      req_if.packet_id <= '0;
      req_if.now_ms    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_table_fill_and_match();
      test_time_zero_and_wrap();
      test_window_extremes();
      test_input_backpressure();
      test_random_traffic();
      wait_for_verdicts();
      repeat (END_SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
